// File: hdl/hfe_pkg.sv
// Shared types and constants for the header field extractor.
// No dependencies; used by every module in hdl/.
package hfe_pkg;

  localparam int MAX_NAME_BYTES = 16;
  localparam int NAME_LEN_W     = 5;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_INDEX_W    = 2;
  localparam int MAX_RESULTS    = 5;
  localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES_HIGH = 2'd2;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
  } out_item_t;

  // all requests produced by one input byte
  typedef struct packed {
    logic [RES_CNT_W-1:0]        count;
    out_item_t [MAX_RESULTS-1:0] items;
  } bundle_t;

endpackage

// File: hdl/header_field_extractor.sv
// Header field extractor, top level: front end, bundle queue and output stage.
// Depends on hfe_pkg, hfe_front, hfe_queue, hfe_back.
//
// Takes one header byte per cycle and returns the value of the configured
// header field as a stream of requests: restart, value bytes, end of input.
// Each input byte is decoded in the cycle it is accepted; its requests (one
// to four; a byte with none pushes nothing) are queued as one bundle in a
// four-entry queue. The output stage sends one request per cycle while
// out_ready allows, and the input only stalls once the queue fills. A byte's
// first request passes through its queue slot, then the output register.
// Configuration writes take effect at once; write only while the block is idle.
module header_field_extractor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hfe_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hfe_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [hfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hfe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic             q_full;
  logic             push;
  hfe_pkg::bundle_t push_data;
  logic             pop;
  logic             head_valid;
  hfe_pkg::bundle_t head;

  hfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  hfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  hfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("bundle pushed into full queue");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_head_count_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head.count != '0) &&
                   (head.count <= hfe_pkg::RES_CNT_W'(hfe_pkg::MAX_RESULTS)))
    else $error("queued bundle has bad request count");

  a_nonbyte_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.out_kind != hfe_pkg::KIND_BYTE) |-> out_data.out_byte == 8'd0)
    else $error("restart or end request carries data");

endmodule

// File: hdl/hfe_front.sv
// Front end: accepts header bytes, runs line/name matching, builds result bundles.
// Holds the configuration registers. Depends on hfe_pkg.
module hfe_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  hfe_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [hfe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hfe_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                q_full,
  output logic                                push,
  output hfe_pkg::bundle_t                    push_data
);

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_MATCH,
    PH_SKIP_HDR,
    PH_SKIP_FOLD,
    PH_EMIT,
    PH_IGNORE
  } phase_t;

  typedef struct packed {
    phase_t                           phase;
    logic [hfe_pkg::NAME_LEN_W-1:0]   pos;
    logic                             capture;
  } line_state_t;

  typedef struct packed {
    line_state_t                st;
    logic [1:0]                 cnt;
    hfe_pkg::out_item_t [1:0]   item;
  } lb_t;

  logic [hfe_pkg::NAME_LEN_W-1:0]   name_length;
  logic [hfe_pkg::CFG_DATA_W-1:0]   name_bytes_low;
  logic [hfe_pkg::CFG_DATA_W-1:0]   name_bytes_high;
  line_state_t                      line_st;
  logic                             cr_held;

  logic [hfe_pkg::NAME_LEN_W-1:0]   eff_len;
  logic [2*hfe_pkg::CFG_DATA_W-1:0] name_all;
  line_state_t                      line_st_next;
  logic                             cr_held_next;
  lb_t                              cr_res;
  lb_t                              byte_res;
  logic                             do_cr;
  logic                             do_byte;
  logic                             accept;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  function automatic lb_t match_byte(line_state_t s, logic [7:0] c,
                                     logic [hfe_pkg::NAME_LEN_W-1:0] len,
                                     logic [2*hfe_pkg::CFG_DATA_W-1:0] name);
    lb_t        r;
    logic [7:0] nb;
    r.st   = s;
    r.cnt  = '0;
    r.item = '0;
    nb     = name[{s.pos[3:0], 3'b000} +: 8];
    if (s.pos < len) begin
      if (fold_case(c) == fold_case(nb)) begin
        r.st.pos   = s.pos + 1'b1;
        r.st.phase = PH_MATCH;
      end else begin
        r.st.phase = PH_IGNORE;
      end
    end else if (c == hfe_pkg::CH_COLON) begin
      r.cnt                = 2'd1;
      r.item[0].out_kind   = hfe_pkg::KIND_RESTART;
      r.st.capture         = 1'b1;
      r.st.phase           = PH_SKIP_HDR;
    end else begin
      r.st.phase = PH_IGNORE;
    end
    return r;
  endfunction

  function automatic lb_t line_byte(line_state_t s, logic [7:0] c,
                                    logic [hfe_pkg::NAME_LEN_W-1:0] len,
                                    logic [2*hfe_pkg::CFG_DATA_W-1:0] name);
    lb_t         r;
    line_state_t t;
    logic        ws;
    r.st   = s;
    r.cnt  = '0;
    r.item = '0;
    t      = s;
    ws     = (c == hfe_pkg::CH_SPACE) || (c == hfe_pkg::CH_TAB);
    if (c == hfe_pkg::CH_LF) begin
      if (s.phase == PH_LINE_START) r.st.capture = 1'b0;
      r.st.phase = PH_LINE_START;
      r.st.pos   = '0;
    end else begin
      unique case (s.phase)
        PH_LINE_START: begin
          if (s.capture && ws) begin
            r.st.phase = PH_SKIP_FOLD;
          end else begin
            t.capture = 1'b0;
            t.pos     = '0;
            r         = match_byte(t, c, len, name);
          end
        end
        PH_MATCH: r = match_byte(s, c, len, name);
        PH_SKIP_HDR: begin
          if (!ws) begin
            r.cnt              = 2'd1;
            r.item[0].out_kind = hfe_pkg::KIND_BYTE;
            r.item[0].out_byte = c;
            r.st.phase         = PH_EMIT;
          end
        end
        PH_SKIP_FOLD: begin
          if (!ws) begin
            r.cnt              = 2'd2;
            r.item[0].out_kind = hfe_pkg::KIND_BYTE;
            r.item[0].out_byte = hfe_pkg::CH_SPACE;
            r.item[1].out_kind = hfe_pkg::KIND_BYTE;
            r.item[1].out_byte = c;
            r.st.phase         = PH_EMIT;
          end
        end
        PH_EMIT: begin
          r.cnt              = 2'd1;
          r.item[0].out_kind = hfe_pkg::KIND_BYTE;
          r.item[0].out_byte = c;
        end
        default: r.st.phase = PH_IGNORE;
      endcase
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (push_data.count != '0);
  assign eff_len  = (name_length > hfe_pkg::NAME_LEN_W'(hfe_pkg::MAX_NAME_BYTES))
                    ? hfe_pkg::NAME_LEN_W'(hfe_pkg::MAX_NAME_BYTES) : name_length;
  assign name_all = {name_bytes_high, name_bytes_low};

  always_comb begin
    logic [hfe_pkg::RES_CNT_W-1:0] n;
    // held CR is replayed as a line byte unless it pairs with LF
    if (in_data.in_byte == hfe_pkg::CH_CR) begin
      do_cr        = cr_held;
      do_byte      = 1'b0;
      cr_held_next = !in_data.in_last;
    end else begin
      do_cr        = cr_held && (in_data.in_byte != hfe_pkg::CH_LF);
      do_byte      = 1'b1;
      cr_held_next = 1'b0;
    end

    if (do_cr) begin
      cr_res = line_byte(line_st, hfe_pkg::CH_CR, eff_len, name_all);
    end else begin
      cr_res.st   = line_st;
      cr_res.cnt  = '0;
      cr_res.item = '0;
    end

    if (do_byte) begin
      byte_res = line_byte(cr_res.st, in_data.in_byte, eff_len, name_all);
    end else begin
      byte_res.st   = cr_res.st;
      byte_res.cnt  = '0;
      byte_res.item = '0;
    end

    line_st_next    = byte_res.st;
    n               = '0;
    push_data.items = '0;
    for (int k = 0; k < 2; k++) begin
      if (2'(k) < cr_res.cnt) begin
        push_data.items[n] = cr_res.item[k];
        n = n + 1'b1;
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (2'(k) < byte_res.cnt) begin
        push_data.items[n] = byte_res.item[k];
        n = n + 1'b1;
      end
    end
    if (in_data.in_last) begin
      push_data.items[n].out_kind = hfe_pkg::KIND_END;
      push_data.items[n].out_byte = '0;
      n = n + 1'b1;
      line_st_next.phase   = PH_LINE_START;
      line_st_next.pos     = '0;
      line_st_next.capture = 1'b0;
      cr_held_next         = 1'b0;
    end
    push_data.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length     <= '0;
      name_bytes_low  <= '0;
      name_bytes_high <= '0;
      line_st.phase   <= PH_LINE_START;
      line_st.pos     <= '0;
      line_st.capture <= 1'b0;
      cr_held         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hfe_pkg::REG_NAME_LENGTH:
            name_length <= cfg_data[hfe_pkg::NAME_LEN_W-1:0];
          hfe_pkg::REG_NAME_BYTES_LOW:  name_bytes_low  <= cfg_data;
          hfe_pkg::REG_NAME_BYTES_HIGH: name_bytes_high <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        line_st <= line_st_next;
        cr_held <= cr_held_next;
      end
    end
  end

endmodule

// File: hdl/hfe_queue.sv
// Small FIFO of result bundles between the front end and the output stage.
// Depends on hfe_pkg.
module hfe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hfe_pkg::bundle_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output hfe_pkg::bundle_t head
);

  hfe_pkg::bundle_t                 slots [hfe_pkg::QUEUE_DEPTH];
  logic [hfe_pkg::QPTR_W-1:0]       wr_ptr;
  logic [hfe_pkg::QPTR_W-1:0]       rd_ptr;
  logic [hfe_pkg::QCNT_W-1:0]       count;

  assign full       = (count == hfe_pkg::QCNT_W'(hfe_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// File: hdl/hfe_back.sv
// Output stage: walks the head bundle one request per cycle into the output register.
// Holds while out_valid is set and out_ready is low. Depends on hfe_pkg.
module hfe_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  hfe_pkg::bundle_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output hfe_pkg::out_item_t out_data
);

  logic [hfe_pkg::RES_CNT_W-1:0] idx;
  logic                          load;
  logic                          at_end;

  assign load   = head_valid && (!out_valid || out_ready);
  assign at_end = ((idx + 1'b1) == head.count);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= head.items[idx];
  end

endmodule

// File: bench/hfe_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the header field extractor: watches the byte, request and
// register write ports, predicts the requests of each byte and compares them.
// Depends on hfe_pkg.
module hfe_checker
  import hfe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  typedef enum logic [2:0] {
    LINE_START, NAME_MATCH, SKIP_HDR_WS, SKIP_FOLD_WS, COPY_VALUE, SKIP_LINE
  } line_phase_e;

  logic [NAME_LEN_W-1:0] name_len = '0;
  logic [63:0]           name_lo = '0;
  logic [63:0]           name_hi = '0;
  line_phase_e           phase = LINE_START;
  logic [4:0]            name_pos = '0;
  logic                  capturing = 1'b0;
  logic                  cr_held = 1'b0;
  out_item_t             request_q[$];
  out_item_t             oldest;
  int                    errs = 0;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] name_char(input logic [4:0] pos);
    return pos[3] ? name_hi[8*pos[2:0] +: 8] : name_lo[8*pos[2:0] +: 8];
  endfunction

  function automatic logic [4:0] name_limit();
    return (name_len > MAX_NAME_BYTES) ? 5'(MAX_NAME_BYTES) : name_len;
  endfunction

  task automatic expect_request(input logic [1:0] kind, input logic [7:0] b);
    out_item_t r;
    r.out_kind = kind;
    r.out_byte = (kind == KIND_BYTE) ? b : 8'h00;
    request_q = {request_q, r};
  endtask

  task automatic match_name(input logic [7:0] c);
    if (name_pos < name_limit()) begin
      if (to_lower(c) == to_lower(name_char(name_pos))) begin
        name_pos = name_pos + 5'd1;
        phase = NAME_MATCH;
      end else begin
        phase = SKIP_LINE;
      end
    end else if (c == CH_COLON) begin
      expect_request(KIND_RESTART, 8'h00);
      capturing = 1'b1;
      phase = SKIP_HDR_WS;
    end else begin
      phase = SKIP_LINE;
    end
  endtask

  task automatic line_step(input logic [7:0] c);
    logic ws;
    ws = (c == CH_SPACE) || (c == CH_TAB);
    if (c == CH_LF) begin
      // empty line ends the capture
      if (phase == LINE_START) capturing = 1'b0;
      phase = LINE_START;
      name_pos = '0;
    end else begin
      case (phase)
        LINE_START: begin
          if (capturing && ws) begin
            phase = SKIP_FOLD_WS;
          end else begin
            capturing = 1'b0;
            name_pos = '0;
            match_name(c);
          end
        end
        NAME_MATCH: begin
          match_name(c);
        end
        SKIP_HDR_WS: begin
          if (!ws) begin
            expect_request(KIND_BYTE, c);
            phase = COPY_VALUE;
          end
        end
        SKIP_FOLD_WS: begin
          if (!ws) begin
            expect_request(KIND_BYTE, CH_SPACE);
            expect_request(KIND_BYTE, c);
            phase = COPY_VALUE;
          end
        end
        COPY_VALUE: begin
          expect_request(KIND_BYTE, c);
        end
        default: begin
          phase = SKIP_LINE;
        end
      endcase
    end
  endtask

  task automatic predict_requests(input in_item_t it);
    // a CR waits one byte: dropped before LF or at end of input
    if (it.in_byte == CH_CR) begin
      if (cr_held) line_step(CH_CR);
      cr_held = !it.in_last;
    end else begin
      if (cr_held) begin
        cr_held = 1'b0;
        if (it.in_byte != CH_LF) line_step(CH_CR);
      end
      line_step(it.in_byte);
    end
    if (it.in_last) begin
      expect_request(KIND_END, 8'h00);
      phase = LINE_START;
      name_pos = '0;
      capturing = 1'b0;
      cr_held = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      name_len = '0;
      name_lo = '0;
      name_hi = '0;
      phase = LINE_START;
      name_pos = '0;
      capturing = 1'b0;
      cr_held = 1'b0;
      request_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (request_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected request, expected none, actual kind %0d byte %02h",
                   $time, out_data.out_kind, out_data.out_byte);
        end else begin
          oldest = request_q.pop_front();
          if (oldest.out_kind != out_data.out_kind) begin
            errs++;
            $display("%0t: out_kind mismatch, expected %0d, actual %0d",
                     $time, oldest.out_kind, out_data.out_kind);
          end
          if (oldest.out_byte != out_data.out_byte) begin
            errs++;
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, oldest.out_byte, out_data.out_byte);
          end
        end
      end
      if (in_valid && in_ready) predict_requests(in_data);
      if (cfg_we) begin
        case (cfg_index)
          REG_NAME_LENGTH:     name_len = cfg_data[NAME_LEN_W-1:0];
          REG_NAME_BYTES_LOW:  name_lo = cfg_data;
          REG_NAME_BYTES_HIGH: name_hi = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= request_q.size();
    fail_count <= errs;
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Bench top: clock, reset, name registers, header byte stimulus with random
// idling. Depends on hfe_pkg, hfe_checker, header_field_extractor.
module tb;
  import hfe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 30;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fail_count;
  int                     pending;
  int                     send_idle_pct = 0;
  int                     ready_stall_pct = 0;
  int                     cycles = 0;
  logic [7:0]             hdr_name [MAX_NAME_BYTES];
  int                     name_span = 0;
  logic [7:0]             block_q[$];

  header_field_extractor i_dut (.*);

  hfe_checker i_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** header_field_extractor: FAILED **");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    block_q = {block_q, b};
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_block();
    for (int i = 0; i < block_q.size(); i++) send_byte(block_q[i], i == block_q.size() - 1);
    block_q.delete();
  endtask

  // wait until every request is back, then let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_name(input int len, input logic [127:0] bytes);
    for (int i = 0; i < MAX_NAME_BYTES; i++) hdr_name[i] = bytes[8*i +: 8];
    name_span = (len > MAX_NAME_BYTES) ? MAX_NAME_BYTES : len;
    cfg_we <= 1'b1;
    cfg_index <= REG_NAME_LENGTH;
    cfg_data <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_index <= REG_NAME_BYTES_LOW;
    cfg_data <= bytes[63:0];
    @(posedge clk);
    cfg_index <= REG_NAME_BYTES_HIGH;
    cfg_data <= bytes[127:64];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [127:0] random_name();
    logic [127:0] v;
    int r;
    for (int i = 0; i < MAX_NAME_BYTES; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) v[8*i +: 8] = 8'($urandom_range(8'h41, 8'h5A) | ($urandom_range(0, 1) << 5));
      else if (r < 85) v[8*i +: 8] = 8'h2D;
      else if (r < 97) v[8*i +: 8] = 8'($urandom_range(33, 126));
      else v[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    return v;
  endfunction

  function automatic logic [7:0] text_char();
    return ($urandom_range(0, 99) < 90) ? 8'($urandom_range(33, 126))
                                        : 8'($urandom_range(0, 255));
  endfunction

  task automatic add_text(input int n);
    repeat (n) queue_byte(text_char());
  endtask

  task automatic add_ws(input int n);
    repeat (n) queue_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic add_eol();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      queue_byte(CH_CR);
      queue_byte(CH_LF);
    end else if (r < 9) begin
      queue_byte(CH_LF);
    end else begin
      queue_byte(CH_CR);
    end
  endtask

  task automatic add_line();
    int kind;
    int cut;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // wanted header, random letter case
      for (int i = 0; i < name_span; i++) begin
        c = hdr_name[i];
        if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1)) c ^= 8'h20;
        queue_byte(c);
      end
      queue_byte(CH_COLON);
      add_ws($urandom_range(0, 2));
      add_text($urandom_range(0, 6));
      add_eol();
    end else if (kind < 55) begin
      add_ws($urandom_range(1, 2));
      add_text($urandom_range(0, 5));
      add_eol();
    end else if (kind < 70) begin
      repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(8'h61, 8'h7A)));
      queue_byte(CH_COLON);
      add_ws(1);
      add_text($urandom_range(0, 4));
      add_eol();
    end else if (kind < 80) begin
      // name broken off partway
      cut = (name_span == 0) ? 0 : $urandom_range(0, name_span - 1);
      for (int i = 0; i < cut; i++) queue_byte(hdr_name[i]);
      queue_byte(text_char());
      queue_byte(CH_COLON);
      add_text($urandom_range(0, 3));
      add_eol();
    end else if (kind < 85) begin
      add_eol();
    end else begin
      repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    string opening;
    int sent;
    bit paused;
    opening = "aB:\t x\r\n \r\n\t y\r\rz\n\nAB:q";
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // folding, whitespace-only fold, lone CR, empty line, CR at end of input
    write_name(2, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_6241});
    for (int i = 0; i < opening.len(); i++) queue_byte(opening[i]);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(CH_CR);
    send_block();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          ready_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 65;
          ready_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          ready_stall_pct = 65;
        end
        default: begin
          send_idle_pct = 14;
          ready_stall_pct = 14;
        end
      endcase
      case (ph)
        0: write_name(0, random_name());
        1: write_name(MAX_NAME_BYTES, random_name());
        2: write_name(31, random_name());
        default: write_name((ph % 2) ? $urandom_range(1, 15) : $urandom_range(0, 31),
                            random_name());
      endcase
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_BYTES) begin
        repeat ($urandom_range(1, 4)) add_line();
        if ($urandom_range(0, 4) == 0) queue_byte(CH_CR);
        sent += block_q.size();
        send_block();
        if (ph == 2 && !paused && sent >= PHASE_BYTES / 2) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("** header_field_extractor: PASSED **");
    end else begin
      $display("** header_field_extractor: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/hfe_pkg.sv
hdl/hfe_front.sv
hdl/hfe_queue.sv
hdl/hfe_back.sv
hdl/header_field_extractor.sv
bench/hfe_checker.sv
bench/tb.sv
